>>> hdl/vtdt_pkg.sv
// shared types and constants for the vertex triplet dedup table
`default_nettype none
package vtdt_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned IdxW       = 24;
  localparam int unsigned SlotW      = 12;
  localparam int unsigned CountW     = 13;

  typedef struct packed {
    logic            first_of_mesh;
    logic [IdxW-1:0] pos_index;
    logic [IdxW-1:0] normal_index;
    logic [IdxW-1:0] tex_index;
  } vtdt_req_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              is_new;
    logic              table_full;
    logic [CountW-1:0] unique_count;
  } vtdt_rsp_t;

  typedef struct packed {
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] normal;
    logic [IdxW-1:0] tex;
  } vtdt_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } vtdt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic more;
  } vtdt_stat_t;

endpackage
`default_nettype wire

>>> hdl/vtdt_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module vtdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/vtdt_ctrl.sv
// scan controller: load, issue reads, finish
`default_nettype none
module vtdt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire vtdt_pkg::vtdt_stat_t stat_i,
  output vtdt_pkg::vtdt_cmd_t     cmd_o
);
  import vtdt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
          busy_d     = 1'b1;
        end
      end
      ST_SCAN: begin
        // a hit, or nothing left to read and the last compare missed
        if (stat_i.hit || !stat_i.more) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
          busy_d       = 1'b0;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

`ifndef SYNTH
  a_busy_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q == ST_SCAN)) else $error("busy out of step with state");
  a_finish_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_q) else $error("still busy after finish");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.issue, cmd_o.finish})) else $error("commands overlap");
`endif

endmodule
`default_nettype wire

>>> hdl/vtdt_dp.sv
// datapath: key register, table ram, scan pointer, fill count, result register
`default_nettype none
module vtdt_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vtdt_pkg::vtdt_req_t req_i,
  input  wire vtdt_pkg::vtdt_cmd_t cmd_i,
  output vtdt_pkg::vtdt_stat_t    stat_o,
  output vtdt_pkg::vtdt_rsp_t     rsp_o,
  output logic                    done_o
);
  import vtdt_pkg::*;

  vtdt_entry_t     key_q, key_d;
  vtdt_entry_t     rd_entry;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [AddrW-1:0] cmp_idx_q;
  logic            cmp_vld_q, cmp_vld_d;
  vtdt_rsp_t       rsp_q, rsp_d;
  logic            done_q;
  logic            hit;
  logic            room;
  logic            wr_en;

  vtdt_ram #(
    .Width($bits(vtdt_entry_t)),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(fill_q[AddrW-1:0]),
    .wdata_i(key_q),
    .re_i   (cmd_i.issue),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rd_entry)
  );

  assign hit  = cmp_vld_q && (rd_entry == key_q);
  assign room = fill_q < CntW'(TableDepth);

  assign stat_o.hit  = hit;
  assign stat_o.more = rd_idx_q < fill_q;

  assign wr_en = cmd_i.finish && !hit && room;

  always_comb begin
    key_d     = key_q;
    fill_d    = fill_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = cmd_i.issue;
    rsp_d     = rsp_q;
    if (cmd_i.load) begin
      key_d.pos    = req_i.pos_index;
      key_d.normal = req_i.normal_index;
      key_d.tex    = req_i.tex_index;
      rd_idx_d     = '0;
      if (req_i.first_of_mesh) begin
        fill_d = '0;
      end
    end
    if (cmd_i.issue) begin
      rd_idx_d = rd_idx_q + CntW'(1);
    end
    if (cmd_i.finish) begin
      rsp_d.is_new     = 1'b0;
      rsp_d.table_full = 1'b0;
      priority if (hit) begin
        rsp_d.slot = SlotW'(cmp_idx_q);
      end else if (room) begin
        rsp_d.slot   = SlotW'(fill_q);
        rsp_d.is_new = 1'b1;
        fill_d       = fill_q + CntW'(1);
      end else begin
        rsp_d.slot       = '0;
        rsp_d.table_full = 1'b1;
      end
      rsp_d.unique_count = CountW'(fill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      fill_q    <= fill_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= cmd_i.finish;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rsp_q     <= rsp_d;
    cmp_idx_q <= rd_idx_q[AddrW-1:0];
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableDepth)) else $error("fill count past table depth");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + CntW'(1) || fill_q == '0)
    else $error("fill count jumped");
  a_new_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.is_new |->
      rsp_q.slot == SlotW'(rsp_q.unique_count - CountW'(1)))
    else $error("new word not placed at end of table");
  a_full_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.table_full |-> !rsp_q.is_new && fill_q == CntW'(TableDepth))
    else $error("full flag with free slots");
`endif

endmodule
`default_nettype wire

>>> hdl/vertex_triplet_dedup_table_core.sv
// vertex triplet dedup table: one triplet in, its slot out
// throughput: one word at a time, the scan reads one table entry per cycle from the
//   single read port of the table ram; busy falls in the cycle the result strobes
// reset clears the fill count and the controller; table contents are left as they are
// the result stays on rsp_o until the next one; done_o marks it for one cycle and cannot be stalled
`default_nettype none
module vertex_triplet_dedup_table_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire vtdt_pkg::vtdt_req_t req_i,
  output vtdt_pkg::vtdt_rsp_t      rsp_o,
  output logic                     done_o
);
  import vtdt_pkg::*;

  vtdt_cmd_t  cmd;
  vtdt_stat_t stat;

  vtdt_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  vtdt_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

endmodule
`default_nettype wire
